@@ sv/assert_macros.svh @@
// Assertion helpers used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ sv/rlst_pkg.sv @@
// ----------------------------------------------------------------------------
// rlst_pkg
// Types, constants and helpers for the reference-counted lock slot table.
// ----------------------------------------------------------------------------
package rlst_pkg;

   localparam int NUM_SLOTS  = 16;
   localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int ID_W       = 32;
   localparam int COUNT_W    = 16;
   localparam int SLOT_W     = 4;
   localparam int STATUS_W   = 3;

   localparam logic [ID_W-1:0]    FREE_ID   = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_JOINED    = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_NEW       = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_SATURATED = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_RESERVED  = 3'd5;

   typedef struct packed {
      logic            operation;
      logic [ID_W-1:0] file_id;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  use_count;
      logic                slot_freed;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic compare;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic out_full;
   } stat_type;

   function automatic logic [SLOT_IDX_W-1:0] lowest_index(input logic [NUM_SLOTS-1:0] vec);
      logic [SLOT_IDX_W-1:0] idx;
      idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = SLOT_IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

@@ sv/rlst_ctrl.sv @@
// ----------------------------------------------------------------------------
// rlst_ctrl
// Sequencer: capture a transaction, compare, then update table and result.
// ----------------------------------------------------------------------------
module rlst_ctrl import rlst_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_COMPARE = 2'd1;
   localparam logic [1:0] S_UPDATE  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       out_blocked;

   assign out_blocked = stat.out_full && rsp_stall;
   assign req_stall   = (state_ff != S_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.compare = 1'b0;
      cmd.update  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = S_UPDATE;
         end
         S_UPDATE: begin
            if (!out_blocked) begin
               cmd.update = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/rlst_datapath.sv @@
// ----------------------------------------------------------------------------
// rlst_datapath
// Slot table registers, parallel id compare, count update, result register.
// ----------------------------------------------------------------------------
module rlst_datapath import rlst_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   input  logic     rsp_stall,
   output stat_type stat,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   req_type               req_ff;
   logic [NUM_SLOTS-1:0]  match_ff, match_in;
   logic [NUM_SLOTS-1:0]  free_ff, free_in;
   logic                  reserved_ff;
   logic [ID_W-1:0]       ids_ff    [NUM_SLOTS];
   logic [ID_W-1:0]       ids_in    [NUM_SLOTS];
   logic [COUNT_W-1:0]    counts_ff [NUM_SLOTS];
   logic [COUNT_W-1:0]    counts_in [NUM_SLOTS];
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [SLOT_IDX_W-1:0] hit_idx;
   logic [SLOT_IDX_W-1:0] free_idx;
   logic                  hit_any;
   logic                  free_any;
   logic [COUNT_W-1:0]    hit_count;
   logic [COUNT_W-1:0]    dec_count;

   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         match_in[i] = (ids_ff[i] == req_ff.file_id);
         free_in[i]  = (ids_ff[i] == FREE_ID);
      end
   end

   assign hit_idx   = lowest_index(match_ff);
   assign free_idx  = lowest_index(free_ff);
   assign hit_any   = |match_ff;
   assign free_any  = |free_ff;
   assign hit_count = counts_ff[hit_idx];
   assign dec_count = (hit_count == '0) ? '0 : hit_count - COUNT_W'(1);

   always_comb begin
      ids_in    = ids_ff;
      counts_in = counts_ff;
      rsp_in    = '0;
      if (reserved_ff) begin
         rsp_in.status = STAT_RESERVED;
      end else if (req_ff.operation == OP_ACQUIRE) begin
         if (hit_any) begin
            if (hit_count == COUNT_MAX) begin
               rsp_in.status    = STAT_SATURATED;
               rsp_in.use_count = COUNT_MAX;
            end else begin
               counts_in[hit_idx] = hit_count + COUNT_W'(1);
               rsp_in.slot        = SLOT_W'(hit_idx);
               rsp_in.status      = STAT_JOINED;
               rsp_in.use_count   = hit_count + COUNT_W'(1);
            end
         end else if (free_any) begin
            ids_in[free_idx]    = req_ff.file_id;
            counts_in[free_idx] = COUNT_W'(1);
            rsp_in.slot         = SLOT_W'(free_idx);
            rsp_in.status       = STAT_NEW;
            rsp_in.use_count    = COUNT_W'(1);
         end else begin
            rsp_in.status = STAT_FULL;
         end
      end else begin
         if (hit_any) begin
            counts_in[hit_idx] = dec_count;
            rsp_in.slot        = SLOT_W'(hit_idx);
            rsp_in.status      = STAT_JOINED;
            rsp_in.use_count   = dec_count;
            if (dec_count == '0) begin
               ids_in[hit_idx]   = FREE_ID;
               rsp_in.slot_freed = 1'b1;
            end
         end else begin
            rsp_in.status = STAT_NOT_FOUND;
         end
      end
   end

   assign rsp_valid_in = cmd.update | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.compare) begin
         match_ff    <= match_in;
         free_ff     <= free_in;
         reserved_ff <= (req_ff.file_id == FREE_ID);
      end
      if (cmd.update) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            ids_ff[i]    <= FREE_ID;
            counts_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.update) begin
            ids_ff    <= ids_in;
            counts_ff <= counts_in;
         end
      end
   end

   assign stat.out_full = rsp_valid_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

endmodule

@@ sv/refcounted_lock_slot_table_top.sv @@
// ----------------------------------------------------------------------------
// refcounted_lock_slot_table_top: 16-slot reference-counted lock table
// A transaction is accepted only while the sequencer is idle and passes through
// its capture, compare and update steps before the result is valid; a held
// response delays the update step until it is taken.
// Synchronous reset frees every slot (all-ones id, count zero).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module refcounted_lock_slot_table_top import rlst_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;
   logic     rsp_is_err;
   logic     rsp_is_new;
   logic     rsp_freed_ok;

   rlst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rlst_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_is_err   = (rsp_data.status != STAT_JOINED) && (rsp_data.status != STAT_NEW);
   assign rsp_is_new   = (rsp_data.status == STAT_NEW);
   assign rsp_freed_ok = (rsp_data.use_count == '0) && (rsp_data.status == STAT_JOINED);

   `ASSERT_IMPL(a_err_slot_zero, clock, reset, rsp_valid && rsp_is_err, rsp_data.slot == '0)
   `ASSERT_IMPL(a_freed_count_zero, clock, reset, rsp_valid && rsp_data.slot_freed, rsp_freed_ok)
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall)
   `ASSERT_IMPL(a_new_count_one, clock, reset, rsp_valid && rsp_is_new, rsp_data.use_count == COUNT_W'(1))

endmodule

@@ tb/sv/refcounted_lock_slot_table_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// refcounted_lock_slot_table_top_tb: self-checking bench for the lock slot table
// Drives acquire and release transactions with random idling on both channels,
// predicts each response from a local copy of the slot ids and use counts,
// and checks every response field in order. Covers reserved ids, unknown
// releases, a full table, back-pressure and full cleanup.
// ----------------------------------------------------------------------------
module refcounted_lock_slot_table_top_tb;
   import rlst_pkg::*;

   localparam int RSP_LATENCY = 3;
   localparam int POOL_SIZE   = 22;
   localparam int MAX_REPORTS = 200;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic [ID_W-1:0]    lock_id  [NUM_SLOTS];
   logic [COUNT_W-1:0] lock_cnt [NUM_SLOTS];
   rsp_type            lock_rsp_q[$];
   req_type            req_fifo[$];
   logic [ID_W-1:0]    id_pool[POOL_SIZE];

   int n_queued     = 0;
   int n_accepted   = 0;
   int n_checked    = 0;
   int n_errors     = 0;
   int req_gap      = 0;
   int req_max_wait = 3;
   int rsp_wait     = 0;
   int rsp_max_wait = 3;
   int hold_cycles  = 0;
   bit req_taken    = 1'b0;
   int status_seen[8];

   refcounted_lock_slot_table_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic rsp_type predict_lock_op(input req_type r);
      rsp_type res;
      int      hit;
      int      vacant;
      res    = '0;
      hit    = -1;
      vacant = -1;
      if (r.file_id == FREE_ID) begin
         res.status = STAT_RESERVED;
         return res;
      end
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (lock_id[i] == r.file_id) hit = i;
         if (lock_id[i] == FREE_ID) vacant = i;
      end
      if (r.operation == OP_ACQUIRE) begin
         if (hit >= 0) begin
            if (lock_cnt[hit] == COUNT_MAX) begin
               res.status    = STAT_SATURATED;
               res.use_count = COUNT_MAX;
            end else begin
               lock_cnt[hit] = lock_cnt[hit] + COUNT_W'(1);
               res.slot      = SLOT_W'(hit);
               res.status    = STAT_JOINED;
               res.use_count = lock_cnt[hit];
            end
         end else if (vacant < 0) begin
            res.status = STAT_FULL;
         end else begin
            lock_id[vacant]  = r.file_id;
            lock_cnt[vacant] = COUNT_W'(1);
            res.slot         = SLOT_W'(vacant);
            res.status       = STAT_NEW;
            res.use_count    = COUNT_W'(1);
         end
      end else if (hit < 0) begin
         res.status = STAT_NOT_FOUND;
      end else begin
         if (lock_cnt[hit] != 0) lock_cnt[hit] = lock_cnt[hit] - COUNT_W'(1);
         if (lock_cnt[hit] == 0) begin
            lock_id[hit]   = FREE_ID;
            res.slot_freed = 1'b1;
         end
         res.slot      = SLOT_W'(hit);
         res.status    = STAT_JOINED;
         res.use_count = lock_cnt[hit];
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         if (n_errors < MAX_REPORTS)
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         n_errors++;
      end
   endtask

   // request accept -> prediction, then response check
   always @(posedge clock) begin : lock_monitor
      rsp_type want;
      if (!reset && req_valid && !req_stall) begin
         lock_rsp_q.push_back(predict_lock_op(req_data));
         n_accepted++;
         req_taken = 1'b1;
         req_gap   = $urandom_range(0, req_max_wait);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (lock_rsp_q.size() == 0) begin
            if (n_errors < MAX_REPORTS)
               $display("%0t: unexpected response, expected none, actual 0x%h", $time, rsp_data);
            n_errors++;
         end else begin
            want = lock_rsp_q.pop_front();
            check_field("slot", 32'(want.slot), 32'(rsp_data.slot));
            check_field("status", 32'(want.status), 32'(rsp_data.status));
            check_field("use_count", 32'(want.use_count), 32'(rsp_data.use_count));
            check_field("slot_freed", 32'(want.slot_freed), 32'(rsp_data.slot_freed));
            status_seen[want.status]++;
            n_checked++;
         end
         rsp_wait = $urandom_range(0, rsp_max_wait);
      end
   end

   always @(negedge clock) begin
      if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (req_fifo.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= req_fifo.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_taken = 1'b0;
   end

   // long holds take priority over per-transaction waits
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else if (rsp_wait > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_lock_op(input logic op, input logic [ID_W-1:0] id);
      req_type r;
      r.operation = op;
      r.file_id   = id;
      req_fifo.push_back(r);
      n_queued++;
      wait (n_accepted == n_queued);
   endtask

   task automatic wait_idle();
      while (lock_rsp_q.size() != 0) @(posedge clock);
      repeat (RSP_LATENCY + 2) @(posedge clock);
   endtask

   task automatic random_lock_op();
      int              pick;
      logic [ID_W-1:0] id;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         send_lock_op(logic'($urandom_range(0, 1)), FREE_ID);
      end else if (pick < 15) begin
         id = $urandom();
         // fresh ids are either acquired then released, or only released, so they never leak a slot
         if (pick < 9) send_lock_op(OP_ACQUIRE, id);
         send_lock_op(OP_RELEASE, id);
      end else begin
         id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
         send_lock_op(logic'($urandom_range(0, 1)), id);
      end
   endtask

   task automatic run_random(input int count, input int sw, input int rw);
      req_max_wait = sw;
      rsp_max_wait = rw;
      repeat (count) random_lock_op();
   endtask

   task automatic test_reserved_id();
      send_lock_op(OP_ACQUIRE, FREE_ID);
      send_lock_op(OP_RELEASE, FREE_ID);
   endtask

   task automatic test_release_unknown();
      send_lock_op(OP_RELEASE, '0);
   endtask

   task automatic test_alloc_join_free();
      send_lock_op(OP_ACQUIRE, '0);
      send_lock_op(OP_ACQUIRE, '0);
      send_lock_op(OP_ACQUIRE, 32'hFFFF_FFFE);
      send_lock_op(OP_RELEASE, '0);
      send_lock_op(OP_RELEASE, '0);
   endtask

   task automatic test_table_full();
      logic [ID_W-1:0] tmp;
      for (int i = 0; i < 16; i++) begin
         tmp        = $urandom();
         id_pool[i] = {tmp[31:5], 1'b0, 4'(i)};
      end
      id_pool[16] = '0;
      id_pool[17] = 32'hFFFF_FFFE;
      for (int i = 18; i < POOL_SIZE; i++) begin
         tmp        = $urandom();
         id_pool[i] = (tmp == FREE_ID) ? '0 : tmp;
      end
      for (int i = 0; i < 16; i++) send_lock_op(OP_ACQUIRE, id_pool[i]);
      send_lock_op(OP_ACQUIRE, id_pool[0]);
   endtask

   task automatic test_random_traffic();
      run_random(520, 3, 3);
      run_random(220, 0, 0);
      run_random(255, 0, 3);
      run_random(255, 3, 0);
   endtask

   task automatic test_backpressure();
      req_max_wait = 0;
      rsp_max_wait = 0;
      hold_cycles  = 150;
      repeat (20) random_lock_op();
      wait_idle();
      req_max_wait = 1;
      rsp_max_wait = 3;
      hold_cycles  = 40;
      repeat (10) random_lock_op();
   endtask

   task automatic test_release_all();
      logic [ID_W-1:0]    held_id  [NUM_SLOTS];
      logic [COUNT_W-1:0] held_cnt [NUM_SLOTS];
      req_max_wait = 1;
      rsp_max_wait = 1;
      wait_idle();
      held_id  = lock_id;
      held_cnt = lock_cnt;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         if (held_id[s] != FREE_ID) begin
            repeat (held_cnt[s]) send_lock_op(OP_RELEASE, held_id[s]);
         end
      end
   endtask

   initial begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         lock_id[i]  = FREE_ID;
         lock_cnt[i] = '0;
      end
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      test_reserved_id();
      test_release_unknown();
      test_alloc_join_free();
      test_table_full();
      test_random_traffic();
      test_backpressure();
      test_release_all();
      wait_idle();
      $display("Ran %0d transactions, %0d responses checked, %0d mismatches",
               n_accepted, n_checked, n_errors);
      $display("Statuses: joined %0d, new %0d, full %0d, not found %0d, saturated %0d, reserved %0d",
               status_seen[STAT_JOINED], status_seen[STAT_NEW], status_seen[STAT_FULL],
               status_seen[STAT_NOT_FOUND], status_seen[STAT_SATURATED],
               status_seen[STAT_RESERVED]);
      if (n_errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout at %0t", $time);
      $display("Verification failed");
      $finish;
   end

endmodule

@@ refcounted_lock_slot_table_top.f @@
+incdir+sv
sv/rlst_pkg.sv
sv/rlst_ctrl.sv
sv/rlst_datapath.sv
sv/refcounted_lock_slot_table_top.sv
tb/sv/refcounted_lock_slot_table_top_tb.sv
